// ===== rtl/ata_ptf_pkg.sv =====
package ata_ptf_pkg;

    localparam int BUFFER_BYTES_DEF = 512;

    localparam logic [2:0] CMD_BUS_READ   = 3'd0;
    localparam logic [2:0] CMD_BUS_WRITE  = 3'd1;
    localparam logic [2:0] CMD_FILL_BYTE  = 3'd2;
    localparam logic [2:0] CMD_FILL_DONE  = 3'd3;
    localparam logic [2:0] CMD_DRAIN      = 3'd4;
    localparam logic [2:0] CMD_DRAIN_DONE = 3'd5;
    localparam logic [2:0] CMD_RESET      = 3'd6;

    localparam logic [3:0] REG_DATA    = 4'd0;
    localparam logic [3:0] REG_DATA2   = 4'd1;
    localparam logic [3:0] REG_ERROR   = 4'd2;
    localparam logic [3:0] REG_COUNT   = 4'd3;
    localparam logic [3:0] REG_SECTOR  = 4'd4;
    localparam logic [3:0] REG_CYL_LO  = 4'd5;
    localparam logic [3:0] REG_CYL_HI  = 4'd6;
    localparam logic [3:0] REG_HEAD    = 4'd7;
    localparam logic [3:0] REG_COMMAND = 4'd8;

    localparam logic [2:0] CFG_BUS_MODE     = 3'd0;
    localparam logic [2:0] CFG_MASTER       = 3'd1;
    localparam logic [2:0] CFG_SLAVE        = 3'd2;
    localparam logic [2:0] CFG_CYLINDERS    = 3'd3;
    localparam logic [2:0] CFG_HEADS        = 3'd4;
    localparam logic [2:0] CFG_TRACK        = 3'd5;
    localparam logic [2:0] CFG_HALF         = 3'd6;
    localparam logic [2:0] CFG_IMAGE_START  = 3'd7;

    localparam logic [1:0] BUS_8BIT  = 2'd0;
    localparam logic [1:0] BUS_16BIT = 2'd1;
    localparam logic [1:0] BUS_SWAP  = 2'd2;
    localparam logic [1:0] BUS_DATA2 = 2'd3;

    localparam logic [1:0] REQ_NONE     = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_WRITE    = 2'd2;
    localparam logic [1:0] REQ_IDENTITY = 2'd3;

    localparam logic [7:0] ATA_READ_SECTOR  = 8'h20;
    localparam logic [7:0] ATA_WRITE_SECTOR = 8'h30;
    localparam logic [7:0] ATA_IDENTIFY     = 8'hEC;

    localparam logic [7:0] ST_BSY  = 8'h80;
    localparam logic [7:0] ST_DRDY = 8'h40;
    localparam logic [7:0] ST_DRQ  = 8'h08;
    localparam logic [7:0] ST_ERR  = 8'h01;
    localparam logic [7:0] ER_UNC  = 8'h40;
    localparam logic [7:0] ER_IDNF = 8'h10;
    localparam logic [7:0] ER_ABRT = 8'h04;

    localparam logic [7:0] RESET_STATUS   = 8'h72;
    localparam logic [7:0] ALL_ONES       = 8'hFF;
    localparam logic [7:0] ONE_BYTE       = 8'h01;
    localparam int         IDENTITY_BYTES = 'h6a;

    typedef enum logic [2:0] {
        PH_READY,
        PH_PIO_IN,
        PH_PIO_OUT,
        PH_FILL_SEC,
        PH_FILL_ID,
        PH_DRAIN
    } t_phase;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_RD1,
        SQ_RD2,
        SQ_WR2,
        SQ_M1,
        SQ_M2,
        SQ_M3,
        SQ_M4,
        SQ_M5,
        SQ_FIN,
        SQ_DONE
    } t_seq;

endpackage

// ===== rtl/ata_ptf_ram.sv =====
module ata_ptf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ata_pio_task_file_device_unit.sv =====
// ATA PIO task file device with master and slave units sharing one geometry.
// Every input item (bus access, media byte, done or channel reset) is accepted
// only while the sequencer is idle and yields exactly one result. A simple
// item goes from the execute state to the done state; a buffer access adds
// RD1, RD2 or WR2, an LBA sector command M1, M2 and FIN, a CHS one M1 to M5 and
// FIN, set by the single 21x8 multiplier that forms the capacity and the CHS
// sector number in turn and by the one read and one write port of the sector
// buffer memory. A new item may enter while the previous result still waits.
module ata_pio_task_file_device_unit #(
    parameter int BUFFER_BYTES = ata_ptf_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_register_select,
    input  logic [7:0]  i_write_value,
    input  logic        i_media_failed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_value,
    output logic [1:0]  o_media_request,
    output logic [37:0] o_media_offset
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] BUF_END   = CW'(BUFFER_BYTES);
    localparam logic [CW-1:0] HALF_END  = CW'(BUFFER_BYTES / 2);
    localparam logic [CW-1:0] ID_END    = CW'(ata_ptf_pkg::IDENTITY_BYTES);

    logic [1:0]  r_bus_mode;
    logic        r_master, r_slave, r_half;
    logic [15:0] r_cyl_total, r_image_start;
    logic [4:0]  r_head_total;
    logic [7:0]  r_track;

    ata_ptf_pkg::t_seq   r_seq, n_seq;
    ata_ptf_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_cmd, n_cmd;
    logic [3:0]  r_reg, n_reg;
    logic [7:0]  r_val, n_val;
    logic        r_failed, n_failed;
    logic [7:0]  r_err, n_err, r_count, n_count, r_sector, n_sector;
    logic [7:0]  r_cyl_lo, n_cyl_lo, r_cyl_hi, n_cyl_hi, r_head, n_head;
    logic [7:0]  r_status, n_status, r_data2, n_data2;
    logic        r_unit, n_unit;
    logic [CW-1:0] r_bcnt, n_bcnt, r_filled, n_filled;
    logic [37:0] r_pos, n_pos;
    logic [28:0] r_prod, n_prod, r_cap, n_cap, r_num, n_num;
    logic [7:0]  r_rv, n_rv;
    logic [1:0]  r_req, n_req;
    logic [37:0] r_off, n_off;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_o_rv;
    logic [1:0]  r_o_req;
    logic [37:0] r_o_off;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic [20:0]   mul_a;
    logic [7:0]    mul_b;
    logic [28:0]   mul_p;

    logic          present, lba, chs_bad, out_free;
    logic [AW-1:0] idx0, idx1;
    logic [CW-1:0] step, nb;
    logic [7:0]    s0, sec_m1;
    logic [15:0]   cyl;
    logic [3:0]    hd;
    logic [37:0]   pos_new;

    ata_ptf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign present  = r_unit ? r_slave : r_master;
    assign lba      = r_head[6];
    assign cyl      = {r_cyl_hi, r_cyl_lo};
    assign hd       = r_head[3:0];
    assign sec_m1   = r_sector - 8'd1;
    assign chs_bad  = (cyl >= r_cyl_total) || ({1'b0, hd} >= r_head_total) ||
                      (r_sector == 8'd0) || (sec_m1 >= r_track);
    assign idx0     = (r_bus_mode == ata_ptf_pkg::BUS_SWAP) ?
                      (r_bcnt[AW-1:0] ^ AW'(1)) : r_bcnt[AW-1:0];
    assign idx1     = r_bcnt[AW-1:0] + AW'(1);
    assign step     = (r_bus_mode == ata_ptf_pkg::BUS_8BIT ||
                       r_bus_mode == ata_ptf_pkg::BUS_DATA2) ? CW'(2) : CW'(1);
    assign nb       = r_bcnt + step;
    assign s0       = (r_status & ~(ata_ptf_pkg::ST_ERR | ata_ptf_pkg::ST_BSY)) |
                      ata_ptf_pkg::ST_DRDY;
    assign pos_new  = {22'd0, r_image_start} +
                      (r_half ? {1'b0, r_num, 8'd0} : {r_num, 9'd0});
    assign mul_p    = 29'(mul_a * mul_b);
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode    <= '0;
            r_master      <= 1'b0;
            r_slave       <= 1'b0;
            r_cyl_total   <= '0;
            r_head_total  <= '0;
            r_track       <= '0;
            r_half        <= 1'b0;
            r_image_start <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ata_ptf_pkg::CFG_BUS_MODE:    r_bus_mode    <= i_cfg_data[1:0];
                ata_ptf_pkg::CFG_MASTER:      r_master      <= i_cfg_data[0];
                ata_ptf_pkg::CFG_SLAVE:       r_slave       <= i_cfg_data[0];
                ata_ptf_pkg::CFG_CYLINDERS:   r_cyl_total   <= i_cfg_data;
                ata_ptf_pkg::CFG_HEADS:       r_head_total  <= i_cfg_data[4:0];
                ata_ptf_pkg::CFG_TRACK:       r_track       <= i_cfg_data[7:0];
                ata_ptf_pkg::CFG_HALF:        r_half        <= i_cfg_data[0];
                ata_ptf_pkg::CFG_IMAGE_START: r_image_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ata_ptf_pkg::SQ_IDLE;
            r_phase     <= ata_ptf_pkg::PH_READY;
            r_err       <= ata_ptf_pkg::ALL_ONES;
            r_count     <= ata_ptf_pkg::ALL_ONES;
            r_sector    <= ata_ptf_pkg::ALL_ONES;
            r_cyl_lo    <= ata_ptf_pkg::ALL_ONES;
            r_cyl_hi    <= ata_ptf_pkg::ALL_ONES;
            r_head      <= ata_ptf_pkg::ALL_ONES;
            r_status    <= ata_ptf_pkg::ALL_ONES;
            r_data2     <= '0;
            r_unit      <= 1'b0;
            r_bcnt      <= '0;
            r_filled    <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_count     <= n_count;
            r_sector    <= n_sector;
            r_cyl_lo    <= n_cyl_lo;
            r_cyl_hi    <= n_cyl_hi;
            r_head      <= n_head;
            r_status    <= n_status;
            r_data2     <= n_data2;
            r_unit      <= n_unit;
            r_bcnt      <= n_bcnt;
            r_filled    <= n_filled;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_reg    <= n_reg;
        r_val    <= n_val;
        r_failed <= n_failed;
        r_prod   <= n_prod;
        r_cap    <= n_cap;
        r_num    <= n_num;
        r_rv     <= n_rv;
        r_req    <= n_req;
        r_off    <= n_off;
        if (r_seq == ata_ptf_pkg::SQ_DONE && out_free) begin
            r_o_rv  <= r_rv;
            r_o_req <= r_req;
            r_o_off <= r_off;
        end
    end

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            ata_ptf_pkg::SQ_IDLE: begin
                if (i_in_valid) begin
                    n_seq = ata_ptf_pkg::SQ_EXEC;
                end
            end
            ata_ptf_pkg::SQ_EXEC: begin
                n_seq = ata_ptf_pkg::SQ_DONE;
                case (r_cmd)
                    ata_ptf_pkg::CMD_BUS_READ: begin
                        if (present && r_reg == ata_ptf_pkg::REG_DATA &&
                            r_phase == ata_ptf_pkg::PH_PIO_IN) begin
                            n_seq = ata_ptf_pkg::SQ_RD1;
                        end
                    end
                    ata_ptf_pkg::CMD_BUS_WRITE: begin
                        if (r_reg == ata_ptf_pkg::REG_DATA &&
                            r_phase == ata_ptf_pkg::PH_PIO_OUT &&
                            r_bus_mode == ata_ptf_pkg::BUS_DATA2) begin
                            n_seq = ata_ptf_pkg::SQ_WR2;
                        end else if (r_reg == ata_ptf_pkg::REG_COMMAND && present &&
                                     r_phase == ata_ptf_pkg::PH_READY &&
                                     (r_val == ata_ptf_pkg::ATA_READ_SECTOR ||
                                      r_val == ata_ptf_pkg::ATA_WRITE_SECTOR) &&
                                     r_count == ata_ptf_pkg::ONE_BYTE &&
                                     (lba || !chs_bad)) begin
                            n_seq = ata_ptf_pkg::SQ_M1;
                        end
                    end
                    ata_ptf_pkg::CMD_FILL_BYTE: begin
                        if (r_phase == ata_ptf_pkg::PH_FILL_SEC && r_half &&
                            r_filled < BUF_END) begin
                            n_seq = ata_ptf_pkg::SQ_WR2;
                        end
                    end
                    ata_ptf_pkg::CMD_DRAIN: begin
                        if (r_phase == ata_ptf_pkg::PH_DRAIN &&
                            r_bcnt < (r_half ? HALF_END : BUF_END)) begin
                            n_seq = ata_ptf_pkg::SQ_RD1;
                        end
                    end
                    default: ;
                endcase
            end
            ata_ptf_pkg::SQ_RD1: begin
                if (r_cmd == ata_ptf_pkg::CMD_BUS_READ &&
                    r_bus_mode == ata_ptf_pkg::BUS_DATA2) begin
                    n_seq = ata_ptf_pkg::SQ_RD2;
                end else begin
                    n_seq = ata_ptf_pkg::SQ_DONE;
                end
            end
            ata_ptf_pkg::SQ_RD2: n_seq = ata_ptf_pkg::SQ_DONE;
            ata_ptf_pkg::SQ_WR2: n_seq = ata_ptf_pkg::SQ_DONE;
            ata_ptf_pkg::SQ_M1:  n_seq = ata_ptf_pkg::SQ_M2;
            ata_ptf_pkg::SQ_M2:  n_seq = lba ? ata_ptf_pkg::SQ_FIN : ata_ptf_pkg::SQ_M3;
            ata_ptf_pkg::SQ_M3:  n_seq = ata_ptf_pkg::SQ_M4;
            ata_ptf_pkg::SQ_M4:  n_seq = ata_ptf_pkg::SQ_M5;
            ata_ptf_pkg::SQ_M5:  n_seq = ata_ptf_pkg::SQ_FIN;
            ata_ptf_pkg::SQ_FIN: n_seq = ata_ptf_pkg::SQ_DONE;
            ata_ptf_pkg::SQ_DONE: begin
                if (out_free) begin
                    n_seq = ata_ptf_pkg::SQ_IDLE;
                end
            end
            default: n_seq = ata_ptf_pkg::SQ_IDLE;
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_reg    = r_reg;
        n_val    = r_val;
        n_failed = r_failed;
        n_err    = r_err;
        n_count  = r_count;
        n_sector = r_sector;
        n_cyl_lo = r_cyl_lo;
        n_cyl_hi = r_cyl_hi;
        n_head   = r_head;
        n_status = r_status;
        n_data2  = r_data2;
        n_unit   = r_unit;
        n_bcnt   = r_bcnt;
        n_filled = r_filled;
        n_pos    = r_pos;
        n_prod   = r_prod;
        n_cap    = r_cap;
        n_num    = r_num;
        n_rv     = r_rv;
        n_req    = r_req;
        n_off    = r_off;
        ram_we    = 1'b0;
        ram_waddr = idx0;
        ram_wdata = r_val;
        ram_raddr = idx0;
        mul_a     = {5'd0, r_cyl_total};
        mul_b     = {3'd0, r_head_total};
        n_out_valid = (r_out_valid && !i_out_ready) ||
                      (r_seq == ata_ptf_pkg::SQ_DONE);

        case (r_seq)
            ata_ptf_pkg::SQ_IDLE: begin
                n_cmd    = i_cmd;
                n_reg    = i_register_select;
                n_val    = i_write_value;
                n_failed = i_media_failed;
                n_rv     = '0;
                n_req    = ata_ptf_pkg::REQ_NONE;
                n_off    = '0;
            end
            ata_ptf_pkg::SQ_EXEC: begin
                case (r_cmd)
                    ata_ptf_pkg::CMD_BUS_READ: begin
                        if (!present) begin
                            n_rv = ata_ptf_pkg::ALL_ONES;
                        end else begin
                            case (r_reg)
                                ata_ptf_pkg::REG_DATA: begin
                                    if (r_phase != ata_ptf_pkg::PH_PIO_IN) begin
                                        n_rv = ata_ptf_pkg::ALL_ONES;
                                    end
                                end
                                ata_ptf_pkg::REG_DATA2:   n_rv = r_data2;
                                ata_ptf_pkg::REG_ERROR:   n_rv = r_err;
                                ata_ptf_pkg::REG_COUNT:   n_rv = r_count;
                                ata_ptf_pkg::REG_SECTOR:  n_rv = r_sector;
                                ata_ptf_pkg::REG_CYL_LO:  n_rv = r_cyl_lo;
                                ata_ptf_pkg::REG_CYL_HI:  n_rv = r_cyl_hi;
                                ata_ptf_pkg::REG_HEAD:    n_rv = r_head;
                                ata_ptf_pkg::REG_COMMAND: n_rv = r_status;
                                default:                  n_rv = ata_ptf_pkg::ALL_ONES;
                            endcase
                        end
                    end
                    ata_ptf_pkg::CMD_BUS_WRITE: begin
                        case (r_reg)
                            ata_ptf_pkg::REG_DATA: begin
                                if (r_phase == ata_ptf_pkg::PH_PIO_OUT) begin
                                    ram_we = 1'b1;
                                    if (r_bus_mode != ata_ptf_pkg::BUS_DATA2) begin
                                        n_bcnt = nb;
                                        if (nb >= BUF_END) begin
                                            n_phase  = ata_ptf_pkg::PH_DRAIN;
                                            n_bcnt   = '0;
                                            n_status = (r_status & ~ata_ptf_pkg::ST_DRQ) |
                                                       ata_ptf_pkg::ST_BSY;
                                            n_req    = ata_ptf_pkg::REQ_WRITE;
                                            n_off    = r_pos;
                                        end
                                    end
                                end
                            end
                            ata_ptf_pkg::REG_DATA2:  n_data2  = r_val;
                            ata_ptf_pkg::REG_COUNT:  n_count  = r_val;
                            ata_ptf_pkg::REG_SECTOR: n_sector = r_val;
                            ata_ptf_pkg::REG_CYL_LO: n_cyl_lo = r_val;
                            ata_ptf_pkg::REG_CYL_HI: n_cyl_hi = r_val;
                            ata_ptf_pkg::REG_HEAD: begin
                                n_head = r_val;
                                n_unit = r_val[4];
                            end
                            ata_ptf_pkg::REG_COMMAND: begin
                                if (present && r_phase == ata_ptf_pkg::PH_READY) begin
                                    n_err    = '0;
                                    n_status = s0;
                                    case (r_val)
                                        ata_ptf_pkg::ATA_READ_SECTOR,
                                        ata_ptf_pkg::ATA_WRITE_SECTOR: begin
                                            if (r_count != ata_ptf_pkg::ONE_BYTE) begin
                                                n_status = s0 | ata_ptf_pkg::ST_ERR;
                                                n_err    = ata_ptf_pkg::ER_ABRT;
                                            end else if (!lba && chs_bad) begin
                                                n_status = s0 | ata_ptf_pkg::ST_ERR;
                                                n_err    = ata_ptf_pkg::ER_ABRT |
                                                           ata_ptf_pkg::ER_IDNF;
                                            end
                                        end
                                        ata_ptf_pkg::ATA_IDENTIFY: begin
                                            n_phase  = ata_ptf_pkg::PH_FILL_ID;
                                            n_filled = '0;
                                            n_status = s0 | ata_ptf_pkg::ST_BSY;
                                            n_req    = ata_ptf_pkg::REQ_IDENTITY;
                                        end
                                        default: begin
                                            n_status = s0 | ata_ptf_pkg::ST_ERR;
                                            n_err    = ata_ptf_pkg::ER_ABRT;
                                        end
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                    ata_ptf_pkg::CMD_FILL_BYTE: begin
                        ram_waddr = r_filled[AW-1:0];
                        if (r_phase == ata_ptf_pkg::PH_FILL_ID && r_filled < ID_END) begin
                            ram_we   = 1'b1;
                            n_filled = r_filled + CW'(1);
                        end else if (r_phase == ata_ptf_pkg::PH_FILL_SEC &&
                                     r_filled < BUF_END) begin
                            ram_we = 1'b1;
                            if (!r_half) begin
                                n_filled = r_filled + CW'(1);
                            end
                        end
                    end
                    ata_ptf_pkg::CMD_FILL_DONE,
                    ata_ptf_pkg::CMD_DRAIN_DONE: begin
                        if ((r_cmd == ata_ptf_pkg::CMD_FILL_DONE &&
                             (r_phase == ata_ptf_pkg::PH_FILL_SEC ||
                              r_phase == ata_ptf_pkg::PH_FILL_ID)) ||
                            (r_cmd == ata_ptf_pkg::CMD_DRAIN_DONE &&
                             r_phase == ata_ptf_pkg::PH_DRAIN)) begin
                            n_status = r_status & ~ata_ptf_pkg::ST_BSY;
                            n_phase  = ata_ptf_pkg::PH_READY;
                            if (r_failed) begin
                                n_status = (r_status & ~ata_ptf_pkg::ST_BSY) |
                                           ata_ptf_pkg::ST_ERR;
                                n_err    = ata_ptf_pkg::ER_ABRT | ata_ptf_pkg::ER_UNC;
                            end else if (r_cmd == ata_ptf_pkg::CMD_FILL_DONE) begin
                                n_phase  = ata_ptf_pkg::PH_PIO_IN;
                                n_bcnt   = '0;
                                n_status = (r_status & ~ata_ptf_pkg::ST_BSY) |
                                           ata_ptf_pkg::ST_DRQ;
                            end
                        end
                    end
                    ata_ptf_pkg::CMD_DRAIN: begin
                        ram_raddr = r_half ? {r_bcnt[AW-2:0], 1'b0} : r_bcnt[AW-1:0];
                    end
                    ata_ptf_pkg::CMD_RESET: begin
                        n_unit  = 1'b0;
                        n_phase = ata_ptf_pkg::PH_READY;
                        if (r_master || r_slave) begin
                            n_count  = ata_ptf_pkg::ONE_BYTE;
                            n_sector = ata_ptf_pkg::ONE_BYTE;
                            n_cyl_lo = '0;
                            n_cyl_hi = '0;
                            n_head   = '0;
                            n_err    = ata_ptf_pkg::ONE_BYTE;
                            n_status = ata_ptf_pkg::RESET_STATUS;
                        end else begin
                            n_count  = ata_ptf_pkg::ALL_ONES;
                            n_sector = ata_ptf_pkg::ALL_ONES;
                            n_cyl_lo = ata_ptf_pkg::ALL_ONES;
                            n_cyl_hi = ata_ptf_pkg::ALL_ONES;
                            n_head   = ata_ptf_pkg::ALL_ONES;
                            n_err    = ata_ptf_pkg::ALL_ONES;
                            n_status = ata_ptf_pkg::ALL_ONES;
                        end
                    end
                    default: ;
                endcase
            end
            ata_ptf_pkg::SQ_RD1: begin
                if (r_cmd == ata_ptf_pkg::CMD_DRAIN) begin
                    n_rv   = ram_rdata;
                    n_bcnt = r_bcnt + CW'(1);
                end else begin
                    n_rv = ({1'b0, idx0} < r_filled) ? ram_rdata : 8'd0;
                    ram_raddr = idx1;
                    if (r_bus_mode != ata_ptf_pkg::BUS_DATA2) begin
                        n_bcnt = nb;
                        if (nb >= BUF_END) begin
                            n_phase  = ata_ptf_pkg::PH_READY;
                            n_status = r_status & ~ata_ptf_pkg::ST_DRQ;
                        end
                    end
                end
            end
            ata_ptf_pkg::SQ_RD2: begin
                n_data2 = ({1'b0, idx1} < r_filled) ? ram_rdata : 8'd0;
                n_bcnt  = nb;
                if (nb >= BUF_END) begin
                    n_phase  = ata_ptf_pkg::PH_READY;
                    n_status = r_status & ~ata_ptf_pkg::ST_DRQ;
                end
            end
            ata_ptf_pkg::SQ_WR2: begin
                ram_we = 1'b1;
                if (r_cmd == ata_ptf_pkg::CMD_FILL_BYTE) begin
                    ram_waddr = r_filled[AW-1:0] + AW'(1);
                    ram_wdata = ata_ptf_pkg::ALL_ONES;
                    n_filled  = r_filled + CW'(2);
                end else begin
                    ram_waddr = idx1;
                    ram_wdata = r_data2;
                    n_bcnt    = nb;
                    if (nb >= BUF_END) begin
                        n_phase  = ata_ptf_pkg::PH_DRAIN;
                        n_bcnt   = '0;
                        n_status = (r_status & ~ata_ptf_pkg::ST_DRQ) | ata_ptf_pkg::ST_BSY;
                        n_req    = ata_ptf_pkg::REQ_WRITE;
                        n_off    = r_pos;
                    end
                end
            end
            ata_ptf_pkg::SQ_M1: begin
                n_prod = mul_p;
            end
            ata_ptf_pkg::SQ_M2: begin
                mul_a = r_prod[20:0];
                mul_b = r_track;
                n_cap = mul_p;
                n_num = {1'b0, r_head[3:0], r_cyl_hi, r_cyl_lo, r_sector};
            end
            ata_ptf_pkg::SQ_M3: begin
                mul_a  = {5'd0, cyl};
                n_prod = mul_p;
            end
            ata_ptf_pkg::SQ_M4: begin
                mul_a  = r_prod[20:0] + {17'd0, hd};
                mul_b  = r_track;
                n_prod = mul_p;
            end
            ata_ptf_pkg::SQ_M5: begin
                n_num = r_prod + {21'd0, sec_m1};
            end
            ata_ptf_pkg::SQ_FIN: begin
                if (r_num >= r_cap) begin
                    n_status = r_status | ata_ptf_pkg::ST_ERR;
                    n_err    = ata_ptf_pkg::ER_ABRT | ata_ptf_pkg::ER_IDNF;
                end else begin
                    n_pos = pos_new;
                    if (r_val == ata_ptf_pkg::ATA_READ_SECTOR) begin
                        n_phase  = ata_ptf_pkg::PH_FILL_SEC;
                        n_filled = '0;
                        n_status = r_status | ata_ptf_pkg::ST_BSY;
                        n_req    = ata_ptf_pkg::REQ_READ;
                        n_off    = pos_new;
                    end else begin
                        n_phase  = ata_ptf_pkg::PH_PIO_OUT;
                        n_bcnt   = '0;
                        n_status = r_status | ata_ptf_pkg::ST_DRQ;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready      = (r_seq == ata_ptf_pkg::SQ_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_o_rv;
    assign o_media_request = r_o_req;
    assign o_media_offset  = r_o_off;

    a_busy_in_media_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ata_ptf_pkg::PH_FILL_SEC || r_phase == ata_ptf_pkg::PH_FILL_ID ||
         r_phase == ata_ptf_pkg::PH_DRAIN) |-> r_status[7])
        else $error("media phase without BSY");

    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= BUF_END + CW'(1))
        else $error("byte counter out of range");

    a_filled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= BUF_END + CW'(1))
        else $error("fill count out of range");

    a_offset_only_with_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_media_request != ata_ptf_pkg::REQ_READ &&
         o_media_request != ata_ptf_pkg::REQ_WRITE) |-> o_media_offset == 38'd0)
        else $error("media offset without sector request");

endmodule

// ===== tb/tb_ata_pio_task_file_device_unit.sv =====
`timescale 1ns / 1ps

module tb_ata_pio_task_file_device_unit;
    import ata_ptf_pkg::*;

    localparam int TF_ERROR   = 0;
    localparam int TF_FEATURE = 1;
    localparam int TF_COUNT   = 2;
    localparam int TF_SECTOR  = 3;
    localparam int TF_CYL_LO  = 4;
    localparam int TF_CYL_HI  = 5;
    localparam int TF_HEAD    = 6;
    localparam int TF_STATUS  = 7;
    localparam int SECTOR_BYTES = 512;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int ITEMS_PER_SETTING = 310;

    typedef struct packed {
        logic [7:0]  rv;
        logic [1:0]  req;
        logic [37:0] off;
    } result_t;

    typedef struct packed {
        logic [2:0] c;
        logic [3:0] r;
        logic [7:0] v;
        logic       f;
    } item_t;

    typedef struct packed {
        item_t   it;
        logic    chk;
        result_t res;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_cmd = '0;
    logic [3:0]  i_register_select = '0;
    logic [7:0]  i_write_value = '0;
    logic        i_media_failed = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_value;
    logic [1:0]  o_media_request;
    logic [37:0] o_media_offset;

    ata_pio_task_file_device_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_register_select(i_register_select),
        .i_write_value(i_write_value), .i_media_failed(i_media_failed),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_read_value(o_read_value), .o_media_request(o_media_request),
        .o_media_offset(o_media_offset)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [1:0]  cf_bus;
    logic        cf_master, cf_slave, cf_half;
    int unsigned cf_cyl, cf_heads, cf_track, cf_start;

    logic [7:0]  sector_mem [SECTOR_BYTES];
    bit          sector_written [SECTOR_BYTES];
    logic [7:0]  taskfile [8];
    logic [7:0]  data2_byte;
    logic        unit_sel;
    t_phase      phase;
    int unsigned byte_cnt, fill_cnt;
    logic [37:0] sector_pos;

    result_t result_q [$];
    item_t   pending_q [$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle_pct = 22;
    int      recv_idle_pct = 70;
    int      n_results = 0, n_read_req = 0, n_write_req = 0, n_ident_req = 0;
    int      n_items = 0;

    function automatic void channel_reset();
        unit_sel = 1'b0;
        phase = PH_READY;
        if (cf_master || cf_slave) begin
            taskfile[TF_COUNT] = ONE_BYTE;
            taskfile[TF_SECTOR] = ONE_BYTE;
            taskfile[TF_CYL_LO] = '0;
            taskfile[TF_CYL_HI] = '0;
            taskfile[TF_HEAD] = '0;
            taskfile[TF_ERROR] = ONE_BYTE;
            taskfile[TF_STATUS] = RESET_STATUS;
            taskfile[TF_FEATURE] = ALL_ONES;
        end else begin
            foreach (taskfile[k]) taskfile[k] = ALL_ONES;
        end
    endfunction

    function automatic void flag_error(logic [7:0] code);
        taskfile[TF_STATUS] |= ST_ERR;
        taskfile[TF_ERROR] = code;
    endfunction

    function automatic void put_byte(int unsigned idx, logic [7:0] d);
        sector_mem[idx % SECTOR_BYTES] = d;
        sector_written[idx % SECTOR_BYTES] = 1'b1;
    endfunction

    function automatic logic [7:0] pio_byte(int unsigned idx);
        idx = idx % SECTOR_BYTES;
        return (idx < fill_cnt) ? sector_mem[idx] : 8'h00;
    endfunction

    function automatic bit locate_sector();
        longint unsigned capacity, num, cyl, hd, sec;
        capacity = longint'(cf_cyl) * cf_heads * cf_track;
        sec = taskfile[TF_SECTOR];
        if (taskfile[TF_COUNT] != ONE_BYTE) begin
            flag_error(ER_ABRT);
            return 1'b0;
        end
        if (taskfile[TF_HEAD][6]) begin
            num = {taskfile[TF_HEAD][3:0], taskfile[TF_CYL_HI], taskfile[TF_CYL_LO],
                   taskfile[TF_SECTOR]};
        end else begin
            cyl = {taskfile[TF_CYL_HI], taskfile[TF_CYL_LO]};
            hd = taskfile[TF_HEAD][3:0];
            if (cyl >= cf_cyl || hd >= cf_heads || sec == 0 || sec - 1 >= cf_track) begin
                flag_error(ER_ABRT | ER_IDNF);
                return 1'b0;
            end
            num = (cyl * cf_heads + hd) * cf_track + (sec - 1);
        end
        if (num >= capacity) begin
            flag_error(ER_ABRT | ER_IDNF);
            return 1'b0;
        end
        sector_pos = longint'(cf_start) + (num << (cf_half ? 8 : 9));
        return 1'b1;
    endfunction

    function automatic result_t predict_result(item_t it);
        result_t     res;
        bit          present;
        int unsigned idx, lim;
        res = '0;
        present = unit_sel ? cf_slave : cf_master;
        case (it.c)
            CMD_BUS_READ: begin
                if (!present || it.r > REG_COMMAND) begin
                    res.rv = ALL_ONES;
                end else if (it.r == REG_DATA) begin
                    if (phase != PH_PIO_IN) begin
                        res.rv = ALL_ONES;
                    end else begin
                        case (cf_bus)
                            BUS_8BIT: begin
                                res.rv = pio_byte(byte_cnt);
                                byte_cnt += 2;
                            end
                            BUS_16BIT: begin
                                res.rv = pio_byte(byte_cnt);
                                byte_cnt += 1;
                            end
                            BUS_SWAP: begin
                                res.rv = pio_byte(byte_cnt ^ 1);
                                byte_cnt += 1;
                            end
                            default: begin
                                res.rv = pio_byte(byte_cnt);
                                data2_byte = pio_byte(byte_cnt + 1);
                                byte_cnt += 2;
                            end
                        endcase
                        if (byte_cnt >= SECTOR_BYTES) begin
                            phase = PH_READY;
                            taskfile[TF_STATUS] &= ~ST_DRQ;
                        end
                    end
                end else if (it.r == REG_DATA2) begin
                    res.rv = data2_byte;
                end else if (it.r == REG_ERROR) begin
                    res.rv = taskfile[TF_ERROR];
                end else begin
                    res.rv = taskfile[int'(it.r) - 1];
                end
            end
            CMD_BUS_WRITE: begin
                case (it.r)
                    REG_DATA: begin
                        if (phase == PH_PIO_OUT) begin
                            idx = byte_cnt % SECTOR_BYTES;
                            case (cf_bus)
                                BUS_8BIT: begin
                                    put_byte(idx, it.v);
                                    byte_cnt += 2;
                                end
                                BUS_16BIT: begin
                                    put_byte(idx, it.v);
                                    byte_cnt += 1;
                                end
                                BUS_SWAP: begin
                                    put_byte(idx ^ 1, it.v);
                                    byte_cnt += 1;
                                end
                                default: begin
                                    put_byte(idx, it.v);
                                    put_byte(idx + 1, data2_byte);
                                    byte_cnt += 2;
                                end
                            endcase
                            if (byte_cnt >= SECTOR_BYTES) begin
                                phase = PH_DRAIN;
                                byte_cnt = 0;
                                taskfile[TF_STATUS] &= ~ST_DRQ;
                                taskfile[TF_STATUS] |= ST_BSY;
                                res.req = REQ_WRITE;
                                res.off = sector_pos;
                            end
                        end
                    end
                    REG_DATA2: data2_byte = it.v;
                    REG_ERROR: taskfile[TF_FEATURE] = it.v;
                    REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI:
                        taskfile[int'(it.r) - 1] = it.v;
                    REG_HEAD: begin
                        taskfile[TF_HEAD] = it.v;
                        unit_sel = it.v[4];
                    end
                    REG_COMMAND: begin
                        if (present && phase == PH_READY) begin
                            taskfile[TF_ERROR] = '0;
                            taskfile[TF_STATUS] &= ~(ST_ERR | ST_BSY);
                            taskfile[TF_STATUS] |= ST_DRDY;
                            case (it.v)
                                ATA_READ_SECTOR: begin
                                    if (locate_sector()) begin
                                        phase = PH_FILL_SEC;
                                        fill_cnt = 0;
                                        taskfile[TF_STATUS] |= ST_BSY;
                                        res.req = REQ_READ;
                                        res.off = sector_pos;
                                    end
                                end
                                ATA_WRITE_SECTOR: begin
                                    if (locate_sector()) begin
                                        phase = PH_PIO_OUT;
                                        byte_cnt = 0;
                                        taskfile[TF_STATUS] |= ST_DRQ;
                                    end
                                end
                                ATA_IDENTIFY: begin
                                    phase = PH_FILL_ID;
                                    fill_cnt = 0;
                                    taskfile[TF_STATUS] |= ST_BSY;
                                    res.req = REQ_IDENTITY;
                                end
                                default: flag_error(ER_ABRT);
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            CMD_FILL_BYTE: begin
                if (phase == PH_FILL_ID) begin
                    if (fill_cnt < IDENTITY_BYTES) begin
                        put_byte(fill_cnt, it.v);
                        fill_cnt += 1;
                    end
                end else if (phase == PH_FILL_SEC && fill_cnt < SECTOR_BYTES) begin
                    put_byte(fill_cnt, it.v);
                    fill_cnt += 1;
                    if (cf_half) begin
                        put_byte(fill_cnt, ALL_ONES);
                        fill_cnt += 1;
                    end
                end
            end
            CMD_FILL_DONE, CMD_DRAIN_DONE: begin
                if ((it.c == CMD_FILL_DONE && (phase == PH_FILL_SEC || phase == PH_FILL_ID))
                        || (it.c == CMD_DRAIN_DONE && phase == PH_DRAIN)) begin
                    taskfile[TF_STATUS] &= ~ST_BSY;
                    if (it.f) begin
                        phase = PH_READY;
                        flag_error(ER_ABRT | ER_UNC);
                    end else if (it.c == CMD_FILL_DONE) begin
                        phase = PH_PIO_IN;
                        byte_cnt = 0;
                        taskfile[TF_STATUS] |= ST_DRQ;
                    end else begin
                        phase = PH_READY;
                    end
                end
            end
            CMD_DRAIN: begin
                lim = cf_half ? SECTOR_BYTES / 2 : SECTOR_BYTES;
                if (phase == PH_DRAIN && byte_cnt < lim) begin
                    res.rv = cf_half ? sector_mem[(byte_cnt * 2) % SECTOR_BYTES]
                                     : sector_mem[byte_cnt % SECTOR_BYTES];
                    byte_cnt += 1;
                end
            end
            CMD_RESET: channel_reset();
            default: ;
        endcase
        return res;
    endfunction

    function automatic item_t mk(logic [2:0] c, logic [3:0] r, logic [7:0] v, logic f);
        item_t it;
        it.c = c;
        it.r = r;
        it.v = v;
        it.f = f;
        return it;
    endfunction

    function automatic item_t next_item();
        int unsigned     p, lim, idx, q;
        longint unsigned capacity, num;
        logic [15:0]     cy;
        logic [3:0]      hd;
        logic [7:0]      sc, hv, code;
        logic            u;
        if (pending_q.size() != 0) return pending_q.pop_front();
        p = $urandom_range(99);
        if (p < 4) return mk($urandom_range(7), $urandom_range(15), $urandom_range(255),
                             $urandom_range(1));
        case (phase)
            PH_READY: begin
                if (p < 40) begin
                    u = (cf_slave && !cf_master) ? 1'b1 :
                        (cf_master && !cf_slave) ? 1'b0 : 1'($urandom_range(1));
                    if ($urandom_range(9) == 0) u = ~u;
                    capacity = longint'(cf_cyl) * cf_heads * cf_track;
                    if ($urandom_range(1) && capacity != 0) begin
                        num = {$urandom, $urandom} % capacity;
                        sc = num[7:0];
                        cy = num[23:8];
                        hv = {1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)), u,
                              num[27:24]};
                    end else begin
                        cy = cf_cyl != 0 ? $urandom_range(cf_cyl - 1) : $urandom_range(65535);
                        hd = cf_heads != 0 ? $urandom_range(cf_heads - 1) : $urandom_range(15);
                        sc = cf_track != 0 ? $urandom_range(cf_track, 1) : $urandom_range(255);
                        if ($urandom_range(7) == 0) sc = $urandom_range(255);
                        if ($urandom_range(7) == 0) cy = $urandom_range(65535);
                        hv = {1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), u, hd};
                    end
                    q = $urandom_range(19);
                    code = q < 9 ? ATA_READ_SECTOR : q < 15 ? ATA_WRITE_SECTOR :
                           q < 19 ? ATA_IDENTIFY : 8'($urandom_range(255));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_COUNT,
                        $urandom_range(9) == 0 ? 8'($urandom_range(255)) : ONE_BYTE, 1'b0));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_SECTOR, sc, 1'b0));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_CYL_LO, cy[7:0], 1'b0));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_CYL_HI, cy[15:8], 1'b0));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_HEAD, hv, 1'b0));
                    pending_q.push_back(mk(CMD_BUS_WRITE, REG_COMMAND, code, 1'b0));
                    return pending_q.pop_front();
                end
                if (p < 70) return mk(CMD_BUS_READ, $urandom_range(8), '0, 1'b0);
                return mk(CMD_BUS_WRITE, $urandom_range(REG_HEAD, REG_DATA2),
                          $urandom_range(255), 1'b0);
            end
            PH_PIO_IN: begin
                if (p < 92) return mk(CMD_BUS_READ, REG_DATA, '0, 1'b0);
                return mk(CMD_BUS_READ, $urandom_range(8), '0, 1'b0);
            end
            PH_PIO_OUT: begin
                if (p < 88) return mk(CMD_BUS_WRITE, REG_DATA, $urandom_range(255), 1'b0);
                if (p < 94) return mk(CMD_BUS_WRITE, REG_DATA2, $urandom_range(255), 1'b0);
                return mk(CMD_BUS_READ, $urandom_range(8), '0, 1'b0);
            end
            PH_FILL_SEC, PH_FILL_ID: begin
                lim = phase == PH_FILL_ID ? IDENTITY_BYTES : SECTOR_BYTES;
                if ((fill_cnt >= lim && p >= 20) || $urandom_range(199) == 0)
                    return mk(CMD_FILL_DONE, $urandom_range(15), $urandom_range(255),
                              $urandom_range(15) == 0);
                if (p < 8) return mk(CMD_BUS_READ, REG_COMMAND, '0, 1'b0);
                return mk(CMD_FILL_BYTE, $urandom_range(15), $urandom_range(255), 1'b0);
            end
            default: begin
                lim = cf_half ? SECTOR_BYTES / 2 : SECTOR_BYTES;
                if (byte_cnt < lim) begin
                    idx = cf_half ? (byte_cnt * 2) % SECTOR_BYTES : byte_cnt % SECTOR_BYTES;
                    if (sector_written[idx]) begin
                        if (p < 95) return mk(CMD_DRAIN, $urandom_range(15), '0, 1'b0);
                        return mk(CMD_BUS_READ, REG_COMMAND, '0, 1'b0);
                    end
                end else if (p < 20) begin
                    return mk(CMD_DRAIN, $urandom_range(15), '0, 1'b0);
                end
                return mk(CMD_DRAIN_DONE, $urandom_range(15), $urandom_range(255),
                          $urandom_range(15) == 0);
            end
        endcase
    endfunction

    task automatic send_item(item_t it, logic chk, result_t typed);
        result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd = it.c;
        i_register_select = it.r;
        i_write_value = it.v;
        i_media_failed = it.f;
        do @(posedge i_clk); while (!o_in_ready);
        res = predict_result(it);
        result_q.push_back(chk ? typed : res);
        n_items++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_cfg(logic [2:0] index, int unsigned value);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value[15:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (index)
            CFG_BUS_MODE:    cf_bus = value[1:0];
            CFG_MASTER:      cf_master = value[0];
            CFG_SLAVE:       cf_slave = value[0];
            CFG_CYLINDERS:   cf_cyl = value[15:0];
            CFG_HEADS:       cf_heads = value[4:0];
            CFG_TRACK:       cf_track = value[7:0];
            CFG_HALF:        cf_half = value[0];
            default:         cf_start = value[15:0];
        endcase
    endtask

    task automatic apply_setting(int unsigned bus, int unsigned mst, int unsigned slv,
                                 int unsigned cyl, int unsigned heads, int unsigned trk,
                                 int unsigned half, int unsigned start);
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
        write_cfg(CFG_BUS_MODE, bus);
        write_cfg(CFG_MASTER, mst);
        write_cfg(CFG_SLAVE, slv);
        write_cfg(CFG_CYLINDERS, cyl);
        write_cfg(CFG_HEADS, heads);
        write_cfg(CFG_TRACK, trk);
        write_cfg(CFG_HALF, half);
        write_cfg(CFG_IMAGE_START, start);
    endtask

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) i_out_ready = ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (result_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_read_value, 0);
            end else begin
                want = result_q.pop_front();
                if (o_read_value !== want.rv) report_mismatch("read_value", o_read_value, want.rv);
                if (o_media_request !== want.req)
                    report_mismatch("media_request", o_media_request, want.req);
                if (o_media_offset !== want.off)
                    report_mismatch("media_offset", o_media_offset, want.off);
                case (want.req)
                    REQ_READ:     n_read_req++;
                    REQ_WRITE:    n_write_req++;
                    REQ_IDENTITY: n_ident_req++;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_ata_pio_task_file_device_unit: FAIL");
            $finish;
        end
    end

    stim_row_t directed_rows [26];

    initial begin
        result_t none;
        none = '0;
        directed_rows = '{
            '{mk(CMD_BUS_READ, REG_COMMAND, 8'h00, 1'b0), 1'b1, '{ALL_ONES, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1, '{ALL_ONES, REQ_NONE, '0}},
            '{mk(CMD_RESET, REG_DATA, 8'h00, 1'b0), 1'b1, '{8'h00, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, REG_COMMAND, 8'h00, 1'b0), 1'b1, '{RESET_STATUS, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1, '{ONE_BYTE, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, REG_COUNT, 8'h00, 1'b0), 1'b1, '{ONE_BYTE, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, REG_SECTOR, 8'h00, 1'b0), 1'b1, '{ONE_BYTE, REQ_NONE, '0}},
            '{mk(CMD_BUS_WRITE, REG_COUNT, 8'h02, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_WRITE, REG_COMMAND, ATA_READ_SECTOR, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1, '{ER_ABRT, REQ_NONE, '0}},
            '{mk(CMD_BUS_WRITE, REG_COUNT, 8'h01, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_WRITE, REG_SECTOR, 8'h00, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_WRITE, REG_COMMAND, ATA_READ_SECTOR, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1,
              '{ER_ABRT | ER_IDNF, REQ_NONE, '0}},
            '{mk(CMD_BUS_WRITE, REG_COMMAND, 8'h99, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1, '{ER_ABRT, REQ_NONE, '0}},
            '{mk(CMD_BUS_WRITE, REG_HEAD, 8'h41, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_WRITE, REG_COMMAND, ATA_WRITE_SECTOR, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1,
              '{ER_ABRT | ER_IDNF, REQ_NONE, '0}},
            '{mk(CMD_BUS_WRITE, REG_HEAD, 8'h40, 1'b0), 1'b0, none},
            '{mk(CMD_BUS_WRITE, REG_COMMAND, ATA_READ_SECTOR, 1'b0), 1'b1,
              '{8'h00, REQ_READ, 38'h100}},
            '{mk(CMD_BUS_READ, REG_DATA, 8'h00, 1'b0), 1'b1, '{ALL_ONES, REQ_NONE, '0}},
            '{mk(CMD_FILL_DONE, REG_DATA, 8'h00, 1'b1), 1'b0, none},
            '{mk(CMD_BUS_READ, REG_ERROR, 8'h00, 1'b0), 1'b1,
              '{ER_ABRT | ER_UNC, REQ_NONE, '0}},
            '{mk(CMD_BUS_READ, 4'd9, 8'h00, 1'b0), 1'b1, '{ALL_ONES, REQ_NONE, '0}},
            '{mk(3'd7, REG_COMMAND, 8'hEC, 1'b1), 1'b0, none}
        };

        cf_bus = BUS_8BIT;
        cf_master = 1'b0;
        cf_slave = 1'b0;
        cf_half = 1'b0;
        cf_cyl = 0;
        cf_heads = 0;
        cf_track = 0;
        cf_start = 0;
        foreach (sector_mem[k]) begin
            sector_mem[k] = '0;
            sector_written[k] = 1'b0;
        end
        data2_byte = '0;
        byte_cnt = 0;
        fill_cnt = 0;
        sector_pos = '0;
        channel_reset();

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        apply_setting(BUS_16BIT, 1, 1, 4, 2, 8, 0, 'h100);
        foreach (directed_rows[k])
            send_item(directed_rows[k].it, directed_rows[k].chk, directed_rows[k].res);

        for (int s = 0; s < 6; s++) begin
            case (s)
                0: apply_setting(BUS_8BIT, 1, 0, 65535, 16, 255, 1, 65535);
                1: apply_setting(BUS_SWAP, 0, 1, 1, 1, 1, 0, 0);
                2: apply_setting(BUS_DATA2, 1, 1, 3, 4, 17, 1, 'h1234);
                3: apply_setting(BUS_DATA2, 0, 0, 0, 0, 0, 0, 7);
                4: apply_setting(BUS_16BIT, 1, 1, 2, 16, 1, 0, 'hA5A5);
                default: apply_setting($urandom_range(3), 1, $urandom_range(1),
                                       $urandom_range(600, 1), $urandom_range(16, 1),
                                       $urandom_range(63, 1), $urandom_range(1),
                                       $urandom_range(65535));
            endcase
            for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
                if (s * ITEMS_PER_SETTING + k < 620) begin
                    send_idle_pct = 22;
                    recv_idle_pct = 70;
                end else if (s * ITEMS_PER_SETTING + k < 1240) begin
                    send_idle_pct = 70;
                    recv_idle_pct = 22;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_item(next_item(), 1'b0, none);
            end
        end

        while (result_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        $display("Covered %0d bus and media transfers over seven disk settings and four bus modes.",
                 n_items);
        $display("Media requests seen: %0d sector reads, %0d write-backs, %0d identify.",
                 n_read_req, n_write_req, n_ident_req);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("tb_ata_pio_task_file_device_unit: PASS");
        end else begin
            $display("tb_ata_pio_task_file_device_unit: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ata_ptf_pkg.sv
rtl/ata_ptf_ram.sv
rtl/ata_pio_task_file_device_unit.sv
tb/tb_ata_pio_task_file_device_unit.sv
